### rtl/fraction_reduce_and_add_assert.svh
// Assertion macros for the fraction unit. They sample on clk and are
// switched off while rst_n is low.
`ifndef FRACTION_REDUCE_AND_ADD_ASSERT_SVH
`define FRACTION_REDUCE_AND_ADD_ASSERT_SVH

// Same-cycle implication.
`define FRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fra_pkg.sv
package fra_pkg;

  // Operand and result widths.
  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W         = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int NUM_W         = 31;
  localparam int DEN_W         = 30;

  // Item kinds.
  localparam logic KIND_MAKE = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

  // One input request.
  typedef struct packed {
    logic                            kind;
    logic signed [OPERAND_WIDTH-1:0] left_numerator;
    logic signed [OPERAND_WIDTH-1:0] left_denominator;
    logic        [MAG_W-1:0]         right_numerator;
    logic        [MAG_W-1:0]         right_denominator;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [NUM_W-1:0] result_numerator;
    logic [DEN_W-1:0] result_denominator;
    logic             is_empty;
  } out_t;

endpackage

### rtl/fraction_reduce_and_add.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    fra_pkg::in_t  (kind and two fractions)
// out_      output     out_valid / out_ready  fra_pkg::out_t (numerator, denominator, empty)
//
// A make request runs binary GCD steps and then two restoring divisions of 15 quotient bits,
// all through one shared compare and subtract unit. An add request passes S_MUL0 to S_MUL3
// on one shared 15 x 15 multiplier and then S_OUT to hand off. Empty results and a make
// request with a zero numerator go straight from idle to the output stage.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register, so a new request is taken while out_ready is low.
// Reset is synchronous on rst_n low and clears the sequencer and out_valid.
`include "fraction_reduce_and_add_assert.svh"

module fraction_reduce_and_add (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fra_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fra_pkg::out_t out_data
);

  localparam int OPW    = fra_pkg::OPERAND_WIDTH;
  localparam int MAG_W  = fra_pkg::MAG_W;
  localparam int PROD_W = fra_pkg::PROD_W;
  localparam int NUM_W  = fra_pkg::NUM_W;
  localparam int DEN_W  = fra_pkg::DEN_W;
  localparam int CNT_W  = $clog2(MAG_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAG_W-1:0]    a_r, a_nxt;
  logic [MAG_W-1:0]    b_r, b_nxt;
  logic [MAG_W-1:0]    n_r, n_nxt;
  logic [MAG_W-1:0]    d_r, d_nxt;
  logic [MAG_W-1:0]    g_r, g_nxt;
  logic [MAG_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [NUM_W-1:0]    res_num_r, res_num_nxt;
  logic [DEN_W-1:0]    res_den_r, res_den_nxt;
  logic                res_empty_r, res_empty_nxt;
  logic                out_valid_r, out_valid_nxt;
  fra_pkg::out_t       out_data_r, out_data_nxt;

  // Shared compare and subtract unit.
  logic [MAG_W:0]      sub_x, sub_y;
  logic [MAG_W+1:0]    sub_diff;
  logic                sub_borrow;
  // Shared multiplier.
  logic [MAG_W-1:0]    mul_x, mul_y;
  logic [PROD_W-1:0]   mul_p;

  logic                a_ge_b;
  logic [MAG_W:0]      div_shift;
  logic [MAG_W-1:0]    div_quo;
  logic                ln_neg, ld_neg, ld_zero, ln_zero;
  logic                out_zero;

  assign sub_diff   = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_borrow = sub_diff[MAG_W+1];
  assign mul_p      = mul_x * mul_y;

  assign a_ge_b    = (a_r >= b_r);
  assign div_shift = {rem_r, quo_r[MAG_W-1]};
  assign div_quo   = {quo_r[MAG_W-2:0], ~sub_borrow};

  assign ln_neg  = in_data.left_numerator[OPW-1];
  assign ld_neg  = in_data.left_denominator[OPW-1];
  assign ln_zero = (in_data.left_numerator == '0);
  assign ld_zero = (in_data.left_denominator == '0);

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    sub_x         = '0;
    sub_y         = '0;
    mul_x         = '0;
    mul_y         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_data.left_numerator[MAG_W-1:0];
          b_nxt = in_data.left_denominator[MAG_W-1:0];
          k_nxt = '0;
          if (in_data.kind == fra_pkg::KIND_MAKE) begin
            n_nxt = in_data.left_numerator[MAG_W-1:0];
            d_nxt = in_data.left_denominator[MAG_W-1:0];
            if (ln_neg || ld_neg || ld_zero) begin
              res_num_nxt   = '0;
              res_den_nxt   = '0;
              res_empty_nxt = 1'b1;
              state_nxt     = S_OUT;
            end else if (ln_zero) begin
              // Zero numerator keeps its denominator as given.
              res_num_nxt   = '0;
              res_den_nxt   = DEN_W'(in_data.left_denominator[MAG_W-1:0]);
              res_empty_nxt = 1'b0;
              state_nxt     = S_OUT;
            end else begin
              state_nxt = S_GCD;
            end
          end else begin
            n_nxt = in_data.right_numerator;
            d_nxt = in_data.right_denominator;
            if (ln_neg || ld_neg || (ln_zero && ld_zero) ||
                (in_data.right_numerator == '0 && in_data.right_denominator == '0)) begin
              res_num_nxt   = '0;
              res_den_nxt   = '0;
              res_empty_nxt = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              state_nxt = S_MUL0;
            end
          end
        end
      end

      // One binary GCD step per cycle; the common factor of two is counted in k.
      S_GCD: begin
        sub_x = a_ge_b ? {1'b0, a_r} : {1'b0, b_r};
        sub_y = a_ge_b ? {1'b0, b_r} : {1'b0, a_r};
        priority if (a_r == '0) begin
          g_nxt     = b_r << k_r;
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_ge_b) begin
          a_nxt = sub_diff[MAG_W:1];
        end else begin
          b_nxt = sub_diff[MAG_W:1];
        end
      end

      // Restoring division by the divisor, one quotient bit per cycle.
      S_DIVN, S_DIVD: begin
        sub_x   = div_shift;
        sub_y   = {1'b0, g_r};
        rem_nxt = sub_borrow ? div_shift[MAG_W-1:0] : sub_diff[MAG_W-1:0];
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          if (state_r == S_DIVN) begin
            res_num_nxt = NUM_W'(div_quo);
            rem_nxt     = '0;
            quo_nxt     = d_r;
            cnt_nxt     = '0;
            state_nxt   = S_DIVD;
          end else begin
            res_den_nxt   = DEN_W'(div_quo);
            res_empty_nxt = 1'b0;
            state_nxt     = S_OUT;
          end
        end
      end

      // Cross products and denominator through the shared multiplier.
      S_MUL0: begin
        mul_x     = a_r;
        mul_y     = d_r;
        prod_nxt  = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_x       = n_r;
        mul_y       = b_r;
        prod_nxt    = mul_p;
        res_num_nxt = NUM_W'(prod_r);
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        mul_x       = b_r;
        mul_y       = d_r;
        prod_nxt    = mul_p;
        res_num_nxt = res_num_r + NUM_W'(prod_r);
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        res_den_nxt   = DEN_W'(prod_r);
        res_empty_nxt = 1'b0;
        state_nxt     = S_OUT;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_numerator   = res_num_r;
          out_data_nxt.result_denominator = res_den_r;
          out_data_nxt.is_empty           = res_empty_r;
          out_valid_nxt                   = 1'b1;
          state_nxt                       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, datapath and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    g_r         <= g_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    res_num_r   <= res_num_nxt;
    res_den_r   <= res_den_nxt;
    res_empty_r <= res_empty_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_zero = (out_data.result_numerator == '0) && (out_data.result_denominator == '0);

  // An empty result carries zero in both fields.
  `FRA_ASSERT_IMP(a_empty_zero, out_valid && out_data.is_empty, out_zero, "empty not 0/0")
  // The GCD loop never runs with a zero second operand.
  `FRA_ASSERT_IMP(a_gcd_b_nonzero, state_r == S_GCD, b_r != '0, "GCD operand b reached zero")
  // An accepted request keeps the unit busy in the next cycle.
  `FRA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

endmodule

### dv/tb_fraction_reduce_and_add.sv
module tb_fraction_reduce_and_add;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  // One queued request plus a flag that holds it back until all results are in.
  typedef struct {
    fra_pkg::in_t req;
    bit           drain_first;
  } pending_req_t;

  localparam int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH;
  localparam int MAG_W         = fra_pkg::MAG_W;
  localparam int NUM_W         = fra_pkg::NUM_W;
  localparam int DEN_W         = fra_pkg::DEN_W;

  localparam int IDLE_LIMIT    = 20000;
  localparam int TAIL_CYCLES   = 100;
  localparam int HOLDOFF_LEN   = 500;
  localparam int HOLDOFF_AFTER = 150;
  localparam int RANDOM_ITEMS  = 700;
  localparam int DRAIN_AT      = 350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fra_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fra_pkg::out_t out_data;

  pending_req_t requests_pending[$];
  fra_pkg::out_t fractions_due[$];
  int requests_queued = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int idle_cycles = 0;

  int burst_left = 8;
  int gap_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;
  fra_pkg::out_t want;

  fraction_reduce_and_add dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Expected result of one request: a reduced fraction or an unreduced sum.
  function automatic fra_pkg::out_t fraction_result(fra_pkg::in_t r);
    longint ln;
    longint ld;
    longint rn;
    longint rd;
    longint a;
    longint b;
    longint t;
    longint g;
    fra_pkg::out_t o;
    ln = r.left_numerator;
    ld = r.left_denominator;
    rn = r.right_numerator;
    rd = r.right_denominator;
    o = '0;
    o.is_empty = 1'b1;
    if (r.kind == fra_pkg::KIND_MAKE) begin
      if (ln >= 0 && ld > 0) begin
        // A zero numerator divides by one, so the denominator stays as given.
        if (ln == 0) begin
          g = 1;
        end else begin
          a = ln;
          b = ld;
          while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
          end
          g = a;
        end
        o.result_numerator = NUM_W'(ln / g);
        o.result_denominator = DEN_W'(ld / g);
        o.is_empty = 1'b0;
      end
    end else begin
      // Negative left operands and 0/0 on either side give the empty fraction.
      if (ln >= 0 && ld >= 0 && !(ln == 0 && ld == 0) && !(rn == 0 && rd == 0)) begin
        o.result_numerator = NUM_W'(ln * rd + rn * ld);
        o.result_denominator = DEN_W'(ld * rd);
        o.is_empty = 1'b0;
      end
    end
    return o;
  endfunction

  task automatic queue_request(logic kind, int ln, int ld, int rn, int rd, bit drain);
    pending_req_t p;
    p.req.kind = kind;
    p.req.left_numerator = OPERAND_WIDTH'(ln);
    p.req.left_denominator = OPERAND_WIDTH'(ld);
    p.req.right_numerator = MAG_W'(rn);
    p.req.right_denominator = MAG_W'(rd);
    p.drain_first = drain;
    requests_pending.push_back(p);
    requests_queued++;
  endtask

  // Driver: offers queued requests in bursts, records the expected result on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fractions_due.push_back(fraction_result(in_data));
        requests_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (requests_pending.size() == 0 ||
                     (requests_pending[0].drain_first && fractions_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= requests_pending[0].req;
          requests_pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // Some bursts run long with no gap to keep the block back to back.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off to back up the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else begin
      if (rx_cycle == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      rx_cycle = (rx_cycle + 1) % 48;
      unique case (rx_mode)
        RX_OPEN: begin
          out_ready <= 1'b1;
        end
        RX_MOSTLY: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        RX_SPARSE: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ~out_ready;
        end
      endcase
    end
  end

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (fractions_due.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d empty=%0b", $time,
                 out_data.result_numerator, out_data.result_denominator, out_data.is_empty);
        errors++;
      end else begin
        want = fractions_due.pop_front();
        results_seen++;
        if (out_data.result_numerator !== want.result_numerator) begin
          $display("%0t: numerator expected %0d actual %0d", $time,
                   want.result_numerator, out_data.result_numerator);
          errors++;
        end
        if (out_data.result_denominator !== want.result_denominator) begin
          $display("%0t: denominator expected %0d actual %0d", $time,
                   want.result_denominator, out_data.result_denominator);
          errors++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $time,
                   want.is_empty, out_data.is_empty);
          errors++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int ln;
    int ld;
    int g;
    int style;
    logic kind;

    // Directed requests: reductions first.
    queue_request(fra_pkg::KIND_MAKE, 0, 1, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 0, 32767, 32767, 32767, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 32767, 32767, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 12, 18, 5, 7, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 32767, 1, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 1, 32767, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 30030, 2310, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 32768 - 2, 16384, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, -1, 5, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 5, 0, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 5, -3, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, -32768, -32768, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_MAKE, 0, 0, 0, 0, 1'b0);
    // Directed sums, including the empty operand and zero denominator cases.
    queue_request(fra_pkg::KIND_ADD, 1, 2, 1, 3, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 0, 0, 1, 2, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 1, 2, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 0, 0, 0, 0, 1'b0);
    queue_request(fra_pkg::KIND_ADD, -1, 2, 1, 2, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 1, -2, 1, 2, 1'b0);
    queue_request(fra_pkg::KIND_ADD, -32768, -32768, 32767, 32767, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 3, 0, 1, 2, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 2, 0, 3, 0, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 0, 5, 0, 7, 1'b0);
    queue_request(fra_pkg::KIND_ADD, 32767, 32767, 32767, 32767, 1'b0);

    // Random requests, mostly well formed with common factors to work the GCD.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = ($urandom_range(0, 1) == 0) ? fra_pkg::KIND_MAKE : fra_pkg::KIND_ADD;
      style = $urandom_range(0, 9);
      if (kind == fra_pkg::KIND_MAKE && style < 6) begin
        g = $urandom_range(1, 300);
        ln = g * $urandom_range(0, 32767 / g);
        ld = g * $urandom_range(1, 32767 / g);
      end else if (style < 7) begin
        ln = (style < 2) ? $urandom_range(0, 40) : $urandom_range(0, 32767);
        ld = (style < 2) ? $urandom_range(0, 40) : $urandom_range(0, 32767);
        if (kind == fra_pkg::KIND_MAKE && ld == 0) begin
          ld = 1;
        end
      end else if (style == 7) begin
        ln = 0;
        ld = $urandom_range(0, 1);
      end else begin
        ln = $urandom_range(0, 65535);
        ld = $urandom_range(0, 65535);
      end
      if (kind == fra_pkg::KIND_ADD && style == 6) begin
        queue_request(kind, ln, ld, 0, $urandom_range(0, 1), i == DRAIN_AT);
      end else begin
        queue_request(kind, ln, ld, $urandom_range(0, 32767), $urandom_range(0, 32767),
                      i == DRAIN_AT);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < requests_queued || fractions_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
